@@ hw/rtl/hts_pkg.sv @@
// Package for the heater thermal safety monitor.
// Holds the item and configuration types, the action codes and the fixed limits.
// No dependencies.
package hts_pkg;

  // One input item per monitor tick.
  typedef struct packed {
    logic [31:0]        time_ms;
    logic               heating;
    logic               reading_valid;
    logic signed [11:0] water_temp;
  } in_item_t;

  // One result item per tick.
  typedef struct packed {
    logic [1:0] overtemp_action;
    logic [1:0] heat_rise_action;
    logic [1:0] stuck_action;
    logic       force_off;
  } out_item_t;

  // Fault action codes.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RAISE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_MONITOR_ENABLE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_WATER_TEMP  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STUCK_TIMEOUT_S = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Timeout in ms fits in 26 bits (65535 s * 1000).
  localparam int unsigned TimeoutW = 26;
  localparam logic [9:0]          MS_PER_S         = 10'd1000;
  localparam logic [TimeoutW-1:0] TIMEOUT_RESET_MS = 26'd1800000;

  // Rise window of five minutes, and temperature limits in 1/16 degree C.
  localparam logic [31:0]        RISE_WINDOW_MS = 32'd300000;
  localparam logic signed [12:0] RISE_LIMIT     = 13'sd32;
  localparam logic signed [12:0] CHANGE_LIMIT   = 13'sd8;

  // Configuration as seen by the evaluation logic.
  typedef struct packed {
    logic                monitor_enable;
    logic [10:0]         max_water_temp;
    logic [TimeoutW-1:0] stuck_ms;
  } cfg_t;

endpackage

@@ hw/rtl/heater_thermal_safety_monitor.sv @@
// Top level of the heater thermal safety monitor.
// Depends on hts_pkg, hts_cfg and hts_eval.
//
// Each accepted item is registered in the input stage, evaluated by hts_eval
// and placed in the result register, where it is held until taken; the block
// takes one item every cycle while results are taken.
// The rate is set by the single evaluation stage between the input and result
// registers. Configuration is written through a plain write port and should
// change only while no item is in flight.
module heater_thermal_safety_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hts_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hts_pkg::out_item_t            out_item_o
);

  hts_pkg::cfg_t      cfg;
  hts_pkg::in_item_t  s1_item_q;
  logic               s1_valid_q;
  hts_pkg::out_item_t result;
  hts_pkg::out_item_t out_item_q;
  logic               out_valid_q;
  logic               advance;
  logic               in_accept;

  hts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The staged item moves into the result register when that is free.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  hts_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
  end

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A disabled monitor produces an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg.monitor_enable |=> out_item_o == '0)
    else $error("disabled monitor produced a nonzero result");

  // Force-off only comes with an overtemperature or stuck raise.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.force_off |->
      (out_item_o.overtemp_action == hts_pkg::ACT_RAISE ||
       out_item_o.stuck_action == hts_pkg::ACT_RAISE))
    else $error("force_off without a raised fault");

  // The input side stalls only when both stages are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

@@ hw/rtl/hts_cfg.sv @@
// Configuration registers of the heater thermal safety monitor.
// Depends on hts_pkg; converts the stuck timeout to milliseconds at write time.
module hts_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output hts_pkg::cfg_t                 cfg_o
);

  logic                          enable_q;
  logic [10:0]                   max_temp_q;
  logic [hts_pkg::TimeoutW-1:0]  stuck_ms_q;
  logic [hts_pkg::TimeoutW-1:0]  stuck_ms_d;

  // Seconds to milliseconds, a single small multiply at the full timeout width.
  assign stuck_ms_d = hts_pkg::TimeoutW'(cfg_wdata_i) * hts_pkg::TimeoutW'(hts_pkg::MS_PER_S);

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      max_temp_q <= '0;
      stuck_ms_q <= hts_pkg::TIMEOUT_RESET_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hts_pkg::REG_MONITOR_ENABLE:  enable_q   <= cfg_wdata_i[0];
        hts_pkg::REG_MAX_WATER_TEMP:  max_temp_q <= cfg_wdata_i[10:0];
        hts_pkg::REG_STUCK_TIMEOUT_S: stuck_ms_q <= stuck_ms_d;
        default: ;
      endcase
    end
  end

  assign cfg_o.monitor_enable = enable_q;
  assign cfg_o.max_water_temp = max_temp_q;
  assign cfg_o.stuck_ms       = stuck_ms_q;

endmodule

@@ hw/rtl/hts_eval.sv @@
// Fault evaluation and tracking state of the heater thermal safety monitor.
// Depends on hts_pkg; computes one result per item and updates state on step_i.
module hts_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hts_pkg::cfg_t       cfg_i,
  input  logic                step_i,
  input  hts_pkg::in_item_t   item_i,
  output hts_pkg::out_item_t  result_o
);

  // Tracking state.
  logic               tracked_on_q, tracked_on_d;
  logic [31:0]        off_time_q, off_time_d;
  logic signed [11:0] base_temp_q, base_temp_d;
  logic               base_valid_q, base_valid_d;
  logic signed [11:0] last_temp_q, last_temp_d;
  logic               last_valid_q, last_valid_d;
  logic [31:0]        last_change_q, last_change_d;

  logic signed [11:0] temp;
  logic               valid;
  logic [31:0]        now;
  logic signed [12:0] max_s;
  logic signed [12:0] rise_diff;
  logic signed [12:0] chg_diff;
  logic [12:0]        chg_abs;
  logic [31:0]        since_off;
  logic [31:0]        since_change;
  logic               changed;

  assign temp  = item_i.water_temp;
  assign valid = item_i.reading_valid;
  assign now   = item_i.time_ms;
  assign max_s = $signed({2'b00, cfg_i.max_water_temp});

  always_comb begin
    result_o      = '0;
    tracked_on_d  = tracked_on_q;
    off_time_d    = off_time_q;
    base_temp_d   = base_temp_q;
    base_valid_d  = base_valid_q;
    last_temp_d   = last_temp_q;
    last_valid_d  = last_valid_q;
    last_change_d = last_change_q;
    rise_diff     = '0;
    chg_diff      = '0;
    chg_abs       = '0;
    since_off     = '0;
    since_change  = '0;
    changed       = 1'b0;

    if (cfg_i.monitor_enable) begin
      // Overtemperature against the ceiling; a ceiling of zero disables it.
      if (cfg_i.max_water_temp != '0 && valid) begin
        if ($signed({temp[11], temp}) >= max_s) begin
          result_o.overtemp_action = hts_pkg::ACT_RAISE;
          result_o.force_off       = item_i.heating;
        end else begin
          result_o.overtemp_action = hts_pkg::ACT_CLEAR;
        end
      end

      if (!item_i.heating) begin
        // Heater off: capture the baseline at the turn-off tick.
        if (tracked_on_q) begin
          base_temp_d  = valid ? temp : '0;
          base_valid_d = valid;
          off_time_d   = now;
        end
        tracked_on_d = 1'b0;
        since_off    = now - off_time_d;
        rise_diff    = {temp[11], temp} - {base_temp_d[11], base_temp_d};
        if (valid && base_valid_d) begin
          if (since_off < hts_pkg::RISE_WINDOW_MS && rise_diff > hts_pkg::RISE_LIMIT) begin
            result_o.heat_rise_action = hts_pkg::ACT_RAISE;
          end else begin
            result_o.heat_rise_action = hts_pkg::ACT_CLEAR;
          end
        end
        result_o.stuck_action = hts_pkg::ACT_CLEAR;
        if (valid) begin
          last_temp_d  = temp;
          last_valid_d = 1'b1;
        end
        last_change_d = '0;
      end else if (!tracked_on_q) begin
        // Heater turning on: record the starting point only.
        tracked_on_d  = 1'b1;
        last_change_d = now;
        last_temp_d   = valid ? temp : '0;
        last_valid_d  = valid;
      end else begin
        // Heater stays on: look for a real temperature change.
        chg_diff = {temp[11], temp} - {last_temp_q[11], last_temp_q};
        chg_abs  = chg_diff[12] ? 13'(-chg_diff) : 13'(chg_diff);
        changed  = valid && (!last_valid_q || $signed(chg_abs) > hts_pkg::CHANGE_LIMIT);
        if (changed) begin
          last_temp_d           = temp;
          last_valid_d          = 1'b1;
          last_change_d         = now;
          result_o.stuck_action = hts_pkg::ACT_CLEAR;
        end
        since_change = now - last_change_d;
        if (since_change >= {6'd0, cfg_i.stuck_ms}) begin
          result_o.stuck_action = hts_pkg::ACT_RAISE;
          result_o.force_off    = 1'b1;
        end
      end
    end
  end

  // State advances only when an item is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_on_q  <= 1'b0;
      off_time_q    <= '0;
      base_temp_q   <= '0;
      base_valid_q  <= 1'b0;
      last_temp_q   <= '0;
      last_valid_q  <= 1'b0;
      last_change_q <= '0;
    end else if (step_i) begin
      tracked_on_q  <= tracked_on_d;
      off_time_q    <= off_time_d;
      base_temp_q   <= base_temp_d;
      base_valid_q  <= base_valid_d;
      last_temp_q   <= last_temp_d;
      last_valid_q  <= last_valid_d;
      last_change_q <= last_change_d;
    end
  end

endmodule

@@ test/tb_heater_thermal_safety_monitor.sv @@
// Testbench for heater_thermal_safety_monitor: directed ticks, then random tick runs
// under several register settings, each result checked against a local predictor.
// Depends on hts_pkg and the heater_thermal_safety_monitor RTL.
module tb_heater_thermal_safety_monitor;
  import hts_pkg::*;

  localparam logic [31:0] RiseWindowMs = 32'd300000;
  localparam int          RiseLimit    = 32;
  localparam int          ChangeLimit  = 8;
  localparam int          StallLimit   = 2000;
  localparam int          PhaseTicks   = 220;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = REG_MONITOR_ENABLE;
  logic [CfgDataW-1:0] cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  in_item_t            in_item     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  out_item_t           out_item;

  // Register copies for the predictor.
  logic                mon_on      = 1'b0;
  logic [10:0]         ceiling     = 11'd0;
  logic [15:0]         stuck_sec   = 16'd1800;

  // Tracking state of the predictor.
  logic                trk_on      = 1'b0;
  logic [31:0]         off_stamp   = '0;
  int                  off_base    = 0;
  logic                off_base_ok = 1'b0;
  int                  prev_temp   = 0;
  logic                prev_temp_ok = 1'b0;
  logic [31:0]         change_stamp = '0;

  // Tick queue, expected verdicts and run bookkeeping.
  in_item_t            tick_fifo[$];
  out_item_t           verdict_q[$];
  out_item_t           want;
  int                  ticks_owed     = 0;
  int                  mismatch_count = 0;
  int                  stall_cycles   = 0;
  int                  send_gap_pct   = 0;
  int                  take_gap_pct   = 0;
  logic                in_took        = 1'b0;

  // Random tick generator state.
  logic [31:0]         gen_now   = '0;
  int                  gen_temp  = 400;
  int                  gen_trend = 0;
  logic                gen_heat  = 1'b0;

  heater_thermal_safety_monitor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #6 clk = ~clk;

  // Predict the verdict for one tick and advance the tracking state.
  function automatic out_item_t thermal_verdict(input in_item_t tick);
    out_item_t   res;
    int          temp;
    int          delta;
    logic [31:0] span;
    logic [31:0] limit_ms;
    res = '{overtemp_action: ACT_NONE, heat_rise_action: ACT_NONE,
            stuck_action: ACT_NONE, force_off: 1'b0};
    temp = int'($signed(tick.water_temp));
    if (mon_on) begin
      // Ceiling check; a zero ceiling turns it off.
      if (ceiling != 11'd0 && tick.reading_valid) begin
        if (temp >= int'(ceiling)) begin
          res.overtemp_action = ACT_RAISE;
          if (tick.heating) res.force_off = 1'b1;
        end else begin
          res.overtemp_action = ACT_CLEAR;
        end
      end
      if (!tick.heating) begin
        // Heater off: latch the baseline on the falling transition.
        if (trk_on) begin
          off_base    = tick.reading_valid ? temp : 0;
          off_base_ok = tick.reading_valid;
          off_stamp   = tick.time_ms;
        end
        trk_on = 1'b0;
        if (tick.reading_valid && off_base_ok) begin
          span = tick.time_ms - off_stamp;
          if (span < RiseWindowMs && temp - off_base > RiseLimit) begin
            res.heat_rise_action = ACT_RAISE;
          end else begin
            res.heat_rise_action = ACT_CLEAR;
          end
        end
        res.stuck_action = ACT_CLEAR;
        if (tick.reading_valid) begin
          prev_temp    = temp;
          prev_temp_ok = 1'b1;
        end
        change_stamp = '0;
      end else if (!trk_on) begin
        // Heater just came on: only record the starting point.
        trk_on       = 1'b1;
        change_stamp = tick.time_ms;
        prev_temp    = tick.reading_valid ? temp : 0;
        prev_temp_ok = tick.reading_valid;
      end else begin
        // Heater stays on: look for a real change, then for the timeout.
        if (tick.reading_valid) begin
          delta = temp - prev_temp;
          if (delta < 0) delta = -delta;
          if (!prev_temp_ok || delta > ChangeLimit) begin
            prev_temp        = temp;
            prev_temp_ok     = 1'b1;
            change_stamp     = tick.time_ms;
            res.stuck_action = ACT_CLEAR;
          end
        end
        limit_ms = 32'(stuck_sec) * 32'd1000;
        span     = tick.time_ms - change_stamp;
        if (span >= limit_ms) begin
          res.stuck_action = ACT_RAISE;
          res.force_off    = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Report one field that differs from its prediction.
  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Queue one tick item for the driver.
  task automatic queue_tick(input logic [31:0] stamp, input logic on, input logic ok,
                            input int temp);
    in_item_t tick;
    tick.time_ms       = stamp;
    tick.heating       = on;
    tick.reading_valid = ok;
    tick.water_temp    = temp[11:0];
    tick_fifo.push_back(tick);
    ticks_owed++;
  endtask

  // Build one random tick: time steps, heater runs and a drifting temperature.
  function automatic in_item_t roll_tick();
    in_item_t tick;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) gen_now = $urandom();
    else if (pick < 6) gen_now += $urandom_range(200000, 400000);
    else gen_now += $urandom_range(0, 1500);
    if ($urandom_range(0, 99) < 12) gen_heat = !gen_heat;
    if ($urandom_range(0, 99) < 10) gen_trend = int'($urandom_range(0, 8)) - 4;
    pick = $urandom_range(0, 99);
    if (pick < 3) gen_temp = int'($urandom_range(0, 4095)) - 2048;
    else if (pick == 3) gen_temp = 2047;
    else if (pick == 4) gen_temp = -2048;
    else if (pick < 55) gen_temp += gen_trend;
    else gen_temp += int'($urandom_range(0, 6)) - 3;
    if (gen_temp > 2047) gen_temp = 2047;
    if (gen_temp < -2048) gen_temp = -2048;
    tick.time_ms       = gen_now;
    tick.heating       = gen_heat;
    tick.reading_valid = ($urandom_range(0, 99) < 88);
    tick.water_temp    = tick.reading_valid ? gen_temp[11:0] : 12'($urandom());
    return tick;
  endfunction

  // Write one register; the predictor copy follows at once since the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CfgDataW-1:0];
    case (idx)
      REG_MONITOR_ENABLE:  mon_on    = value[0];
      REG_MAX_WATER_TEMP:  ceiling   = value[10:0];
      REG_STUCK_TIMEOUT_S: stuck_sec = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued item is taken and every verdict has come back.
  task automatic drain();
    while (ticks_owed != 0 || verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Driver: present the next item once the current one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (tick_fifo.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_item  <= tick_fifo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < take_gap_pct);
    end
  end

  // Monitor: predict on input accept, check on result accept, watch for hangs.
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        verdict_q.push_back(thermal_verdict(in_item));
        ticks_owed--;
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected, actual %p", $time, out_item);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          check_field("overtemp_action", want.overtemp_action, out_item.overtemp_action);
          check_field("heat_rise_action", want.heat_rise_action, out_item.heat_rise_action);
          check_field("stuck_action", want.stuck_action, out_item.stuck_action);
          check_field("force_off", want.force_off, out_item.force_off);
        end
      end
      if ((ticks_owed != 0 || verdict_q.size() != 0) &&
          !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end else begin
        stall_cycles = 0;
      end
    end
  end

  // Stimulus: reset, directed ticks, then random phases under varied settings.
  initial begin
    int n_ticks;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 26;
    take_gap_pct = 88;

    // Monitor disabled after reset: all results are no-action, state held.
    queue_tick(32'd0, 1'b1, 1'b1, 2047);
    queue_tick(32'hFFFF_FFFF, 1'b0, 1'b1, -2048);
    drain();

    write_reg(REG_MONITOR_ENABLE, 1);
    write_reg(REG_MAX_WATER_TEMP, 800);
    write_reg(REG_STUCK_TIMEOUT_S, 1);

    // Off with no baseline, turn on, invalid reading, stuck raise, ceiling hit.
    queue_tick(32'd0, 1'b0, 1'b1, 400);
    queue_tick(32'd100, 1'b1, 1'b1, 400);
    queue_tick(32'd200, 1'b1, 1'b0, 0);
    queue_tick(32'd1300, 1'b1, 1'b1, 404);
    queue_tick(32'd1400, 1'b1, 1'b1, 2047);
    // Turn off and rise past the limit inside the window, then outside it.
    queue_tick(32'd1500, 1'b0, 1'b1, 420);
    queue_tick(32'd2000, 1'b0, 1'b1, 460);
    queue_tick(32'd2100, 1'b0, 1'b1, 900);
    queue_tick(32'd2200, 1'b0, 1'b0, 0);
    queue_tick(32'd302000, 1'b0, 1'b1, 500);
    // Turn on with an invalid reading, so the first valid one counts as change.
    queue_tick(32'd302100, 1'b1, 1'b0, -2048);
    queue_tick(32'd302200, 1'b1, 1'b1, -2048);
    queue_tick(32'd303300, 1'b1, 1'b1, -2045);
    // Turn off with an invalid reading: the baseline stays invalid.
    queue_tick(32'd303400, 1'b0, 1'b0, 0);
    queue_tick(32'd303500, 1'b0, 1'b1, 1000);
    // Time wraps while the heater is on.
    queue_tick(32'hFFFF_FF00, 1'b1, 1'b1, 100);
    queue_tick(32'h0000_0100, 1'b1, 1'b1, 100);
    queue_tick(32'h0000_0400, 1'b1, 1'b1, 100);
    drain();

    // Zero timeout: stuck raises on every on tick after the first.
    write_reg(REG_STUCK_TIMEOUT_S, 0);
    queue_tick(32'd5000, 1'b0, 1'b1, 0);
    queue_tick(32'd5000, 1'b1, 1'b1, 0);
    queue_tick(32'd5000, 1'b1, 1'b1, 0);
    drain();

    // Random phases, each under a new register setting; some also change the idling mode.
    for (int phase = 0; phase < 6; phase++) begin
      n_ticks = PhaseTicks;
      case (phase)
        0: begin
          write_reg(REG_MONITOR_ENABLE, 1);
          write_reg(REG_MAX_WATER_TEMP, 600);
          write_reg(REG_STUCK_TIMEOUT_S, 2);
        end
        1: begin
          write_reg(REG_MAX_WATER_TEMP, 2047);
          write_reg(REG_STUCK_TIMEOUT_S, 0);
        end
        2: begin
          send_gap_pct = 88;
          take_gap_pct = 26;
          write_reg(REG_MONITOR_ENABLE, 0);
          write_reg(REG_MAX_WATER_TEMP, 300);
          write_reg(REG_STUCK_TIMEOUT_S, 5);
          n_ticks = 60;
        end
        3: begin
          write_reg(REG_MONITOR_ENABLE, 1);
          write_reg(REG_MAX_WATER_TEMP, 0);
          write_reg(REG_STUCK_TIMEOUT_S, 65535);
        end
        4: begin
          send_gap_pct = 0;
          take_gap_pct = 0;
          write_reg(REG_MAX_WATER_TEMP, 1);
          write_reg(REG_STUCK_TIMEOUT_S, 1);
        end
        default: begin
          write_reg(REG_MAX_WATER_TEMP, $urandom_range(400, 800));
          write_reg(REG_STUCK_TIMEOUT_S, $urandom_range(1, 4));
        end
      endcase
      gen_temp = $urandom_range(200, 700);
      for (int k = 0; k < n_ticks; k++) begin
        tick_fifo.push_back(roll_tick());
        ticks_owed++;
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/hts_pkg.sv
hw/rtl/hts_cfg.sv
hw/rtl/hts_eval.sv
hw/rtl/heater_thermal_safety_monitor.sv
test/tb_heater_thermal_safety_monitor.sv
